// ===== hw/rtl/nfm_pkg.sv =====
// Shared types and constants for the NOR flash model core.
// Used by the core, its byte RAM wiring and the port checker.
`default_nettype none

package nfm_pkg;

  // Geometry of the store
  localparam int SECTOR_COUNT = 16;
  localparam int SECTOR_BYTES = 4096;
  localparam int STORE_BYTES  = SECTOR_COUNT * SECTOR_BYTES;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int SB_W         = $clog2(SECTOR_BYTES + 1);
  localparam int FLAT_W       = 8 + SB_W + 1;
  localparam int WALK_W       = $clog2(STORE_BYTES + 1);

  // Per-transfer byte counter
  localparam int LEN_W     = 17;
  localparam int COUNT_MAX = 65536;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Operation codes
  localparam logic [1:0] FUNC_READ         = 2'd0;
  localparam logic [1:0] FUNC_WRITE        = 2'd1;
  localparam logic [1:0] FUNC_ERASE_SECTOR = 2'd2;
  localparam logic [1:0] FUNC_ERASE_ALL    = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  sector;
    logic [15:0] offset;
    logic [7:0]  data_in;
    logic        last_of_transfer;
  } nfm_in_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic             in_range;
    logic [LEN_W-1:0] transfer_length;
  } nfm_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nfm_ram.sv =====
// Generic single-port RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module nfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on we, read old contents every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nor_flash_model_core.sv =====
// NOR flash model core: sequencer, address unit and byte store.
// Depends on nfm_pkg and nfm_ram.
//
// Usage: one request beat per byte access or erase command on req, one
// response beat per request on rsp. Both channels use valid/stall; a beat
// moves when valid is high and stall is low.
// Read/write: the flat address sector*SECTOR_BYTES+offset is formed by one
// multiply then one add, the byte is read from the single-port store and,
// for a write, ANDed with data_in and written back. The core takes no new
// request until the response of the last one has been loaded for output.
// Erase sector: the address walker writes 0xFF once per cycle through the
// store's one port across the sector. Erase-all sweeps the whole store.
// Reset: the walker sweeps the whole store to 0xFF with req_stall high;
// the transfer counter clears.
// Receiver stall: a finished response waits in the output register, and one
// further request is still taken and worked up to its response, which then
// holds until the output register frees.
`default_nettype none

module nor_flash_model_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire nfm_pkg::nfm_in_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output nfm_pkg::nfm_out_t    rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_DATA  = 3'd4;
  localparam logic [2:0] S_ERASE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;

  // Latched request and working registers
  nfm_pkg::nfm_in_t                item;
  logic [nfm_pkg::FLAT_W-1:0]      prod;
  logic [nfm_pkg::ADDR_W-1:0]      addr;
  logic [nfm_pkg::WALK_W-1:0]      left;
  logic                            clearing;
  logic [nfm_pkg::LEN_W-1:0]       accepted_count;
  logic [7:0]                      res_data;
  logic                            res_ok;
  logic [nfm_pkg::LEN_W-1:0]       res_len;

  // Store port
  logic                            ram_we;
  logic [7:0]                      ram_wdata;
  logic [7:0]                      ram_rdata;

  logic [nfm_pkg::FLAT_W-1:0]      flat;
  logic                            flat_ok;
  logic                            sector_ok;
  logic [nfm_pkg::LEN_W-1:0]       count_inc;
  logic [7:0]                      merged;
  logic                            out_free;
  logic                            accept;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Address unit: flat address and range checks
  assign flat      = prod + nfm_pkg::FLAT_W'(item.offset);
  assign flat_ok   = flat < nfm_pkg::FLAT_W'(nfm_pkg::STORE_BYTES);
  assign sector_ok = {1'b0, item.sector} < 9'(nfm_pkg::SECTOR_COUNT);
  assign count_inc = (flat_ok && accepted_count < nfm_pkg::LEN_W'(nfm_pkg::COUNT_MAX))
                     ? accepted_count + 1'b1 : accepted_count;

  // Read-modify value: writes AND the data in, reads pass through
  assign merged = (item.func == nfm_pkg::FUNC_WRITE) ? (ram_rdata & item.data_in)
                                                     : ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = nfm_pkg::ERASED_BYTE;
    case (state)
      S_ERASE: begin
        ram_we = 1'b1;
      end
      S_DATA: begin
        ram_we    = (item.func == nfm_pkg::FUNC_WRITE);
        ram_wdata = merged;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  nfm_ram #(
    .WIDTH (8),
    .DEPTH (nfm_pkg::STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_ERASE;
      clearing       <= 1'b1;
      addr           <= '0;
      left           <= nfm_pkg::WALK_W'(nfm_pkg::STORE_BYTES);
      accepted_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            item  <= req;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= nfm_pkg::FLAT_W'(item.sector) *
                   nfm_pkg::FLAT_W'(nfm_pkg::SECTOR_BYTES);
          state <= S_ADD;
        end
        S_ADD: begin
          res_data <= '0;
          res_len  <= '0;
          if (item.func == nfm_pkg::FUNC_ERASE_ALL) begin
            res_ok   <= 1'b1;
            clearing <= 1'b0;
            addr     <= '0;
            left     <= nfm_pkg::WALK_W'(nfm_pkg::STORE_BYTES);
            state    <= S_ERASE;
          end else if (item.func == nfm_pkg::FUNC_ERASE_SECTOR) begin
            res_ok   <= sector_ok;
            clearing <= 1'b0;
            addr     <= prod[nfm_pkg::ADDR_W-1:0];
            left     <= nfm_pkg::WALK_W'(nfm_pkg::SECTOR_BYTES);
            state    <= sector_ok ? S_ERASE : S_DONE;
          end else begin
            res_ok <= flat_ok;
            addr   <= flat[nfm_pkg::ADDR_W-1:0];
            if (item.last_of_transfer) begin
              res_len        <= count_inc;
              accepted_count <= '0;
            end else begin
              accepted_count <= count_inc;
            end
            state <= flat_ok ? S_RD : S_DONE;
          end
        end
        S_RD: begin
          state <= S_DATA;
        end
        S_DATA: begin
          res_data <= merged;
          state    <= S_DONE;
        end
        S_ERASE: begin
          addr <= addr + 1'b1;
          left <= left - 1'b1;
          if (left == nfm_pkg::WALK_W'(1)) begin
            state <= clearing ? S_IDLE : S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.read_data       <= res_data;
      rsp.in_range        <= res_ok;
      rsp.transfer_length <= res_len;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nfm_checker.sv =====
// Port-level checks for the NOR flash model core, bound into nor_flash_model_core.
// Depends on nfm_pkg.
`default_nettype none

module nfm_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_stall,
  input wire nfm_pkg::nfm_in_t  req,
  input wire logic              rsp_valid,
  input wire logic              rsp_stall,
  input wire nfm_pkg::nfm_out_t rsp
);

  // Reset starts the clearing sweep, so no request is taken right after it
  a_stall_after_reset: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request taken right after reset");

  // One request at a time: accept closes the request side next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request taken back to back");

  // A held response beat does not change
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

  // Refused accesses return zero data and counts never pass the cap
  a_rsp_sane: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.in_range || rsp.read_data == 8'd0) &&
                   rsp.transfer_length <= nfm_pkg::LEN_W'(nfm_pkg::COUNT_MAX)))
    else $error("response fields out of range");

endmodule

bind nor_flash_model_core nfm_checker u_nfm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

// ===== bench/nfm_checker.sv =====
// Response checker for the NOR flash model core: watches both channels,
// keeps its own image of the store and compares every response beat.
// Depends on nfm_pkg for the beat types, geometry and operation codes.
`timescale 1ns / 1ps

module nfm_resp_checker
  import nfm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_stall,
  input  nfm_in_t  req,
  input  logic     rsp_valid,
  input  logic     rsp_stall,
  input  nfm_out_t rsp,
  output int       fail_count,
  output int       pending
);

  logic [7:0]       flash_img [0:STORE_BYTES-1];
  logic [LEN_W-1:0] byte_tally;
  nfm_out_t         rsp_due_q [$];
  int               errs = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Count one failure and print it
  function automatic void report(string fld, int unsigned want, int unsigned got);
    errs++;
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
  endfunction

  // Apply one request beat to the store image and return its response
  function automatic nfm_out_t flash_access(nfm_in_t b);
    nfm_out_t r;
    int       flat;
    r = '0;
    case (b.func)
      FUNC_ERASE_SECTOR: begin
        if (int'(b.sector) < SECTOR_COUNT) begin
          for (int a = 0; a < SECTOR_BYTES; a++) begin
            flash_img[int'(b.sector) * SECTOR_BYTES + a] = ERASED_BYTE;
          end
          r.in_range = 1'b1;
        end
      end
      FUNC_ERASE_ALL: begin
        for (int a = 0; a < STORE_BYTES; a++) begin
          flash_img[a] = ERASED_BYTE;
        end
        r.in_range = 1'b1;
      end
      default: begin
        flat = int'(b.sector) * SECTOR_BYTES + int'(b.offset);
        if (flat < STORE_BYTES) begin
          // NOR write can only clear bits
          if (b.func == FUNC_WRITE) begin
            flash_img[flat] = flash_img[flat] & b.data_in;
          end
          r.read_data = flash_img[flat];
          r.in_range  = 1'b1;
          if (byte_tally < COUNT_MAX) begin
            byte_tally++;
          end
        end
        // Report and restart the tally on the closing beat
        if (b.last_of_transfer) begin
          r.transfer_length = byte_tally;
          byte_tally        = '0;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    nfm_out_t want;
    if (rst) begin
      // Hold the image at the erased state through reset
      for (int a = 0; a < STORE_BYTES; a++) begin
        flash_img[a] = ERASED_BYTE;
      end
      byte_tally = '0;
      rsp_due_q.delete();
    end else begin
      // Compare a response beat against the oldest prediction
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due_q.size() == 0) begin
          errs++;
          $display("%0t ns: response beat, expected none, actual %h", $time, rsp);
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp.read_data !== want.read_data) begin
            report("read_data", 32'(want.read_data), 32'(rsp.read_data));
          end
          if (rsp.in_range !== want.in_range) begin
            report("in_range", 32'(want.in_range), 32'(rsp.in_range));
          end
          if (rsp.transfer_length !== want.transfer_length) begin
            report("transfer_length", 32'(want.transfer_length),
                   32'(rsp.transfer_length));
          end
        end
      end
      // Predict the response of each accepted request beat
      if (req_valid && !req_stall) begin
        rsp_due_q.push_back(flash_access(req));
      end
    end
    pending    <= rsp_due_q.size();
    fail_count <= errs;
  end

endmodule

// ===== bench/tb.sv =====
// Top of the NOR flash model core bench: clock, reset, request stimulus,
// response stall and the verdict. Depends on nfm_pkg, the core and nfm_resp_checker.
`timescale 1ns / 1ps

module tb;
  import nfm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int unsigned RANDOM_BEATS = 740;
  // Closing transfer run with no idling on either side
  localparam int unsigned TAIL_BEATS   = 40;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  nfm_in_t  req       = '0;
  logic     rsp_stall = 1'b0;
  logic     req_stall;
  logic     rsp_valid;
  nfm_out_t rsp;

  logic        idle_on    = 1'b1;
  int unsigned stall_left = 0;
  int unsigned sent_cnt   = 0;
  int unsigned cycle_cnt  = 0;
  int          fail_count;
  int          pending;

  nor_flash_model_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  nfm_resp_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stall the response side in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Present one request beat, with an optional gap first, and hold it until taken
  task automatic send_beat(input logic [1:0] func, input logic [7:0] sector,
                           input logic [15:0] offset, input logic [7:0] data,
                           input logic last);
    nfm_in_t b;
    b.func             = func;
    b.sector           = sector;
    b.offset           = offset;
    b.data_in          = data;
    b.last_of_transfer = last;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req       <= b;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    sent_cnt++;
  endtask

  initial begin : stim
    int unsigned goal;
    int unsigned pick;
    int unsigned n;
    int unsigned wipes_left;
    logic [1:0]  op;
    logic [1:0]  f;
    logic [7:0]  sec;
    logic [15:0] off;
    logic        mixed;
    logic        open_end;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: erased read, AND writes, store edges, out-of-range, erases
    send_beat(FUNC_READ,  8'd0, 16'd0, 8'h00, 1'b0);
    send_beat(FUNC_WRITE, 8'd0, 16'd0, 8'h00, 1'b0);
    send_beat(FUNC_READ,  8'd0, 16'd0, 8'hFF, 1'b1);
    send_beat(FUNC_WRITE, 8'(SECTOR_COUNT - 1), 16'(SECTOR_BYTES - 1), 8'hA5, 1'b0);
    send_beat(FUNC_READ,  8'(SECTOR_COUNT - 1), 16'(SECTOR_BYTES - 1), 8'h00, 1'b1);
    send_beat(FUNC_READ,  8'd0, 16'hFFFF, 8'h00, 1'b0);
    send_beat(FUNC_READ,  8'd1, 16'hFFFF, 8'h00, 1'b0);
    send_beat(FUNC_WRITE, 8'hFF, 16'hFFFF, 8'h00, 1'b1);
    send_beat(FUNC_WRITE, 8'(SECTOR_COUNT), 16'd0, 8'h00, 1'b1);
    send_beat(FUNC_READ,  8'd2, 16'd5, 8'h00, 1'b1);
    send_beat(FUNC_ERASE_SECTOR, 8'd0, 16'hFFFF, 8'hFF, 1'b1);
    send_beat(FUNC_READ,  8'd0, 16'd0, 8'h00, 1'b0);
    send_beat(FUNC_ERASE_SECTOR, 8'(SECTOR_COUNT), 16'd0, 8'h00, 1'b0);
    send_beat(FUNC_ERASE_SECTOR, 8'hFF, 16'd0, 8'h00, 1'b1);
    send_beat(FUNC_WRITE, 8'd3, 16'd7, 8'h5A, 1'b0);
    send_beat(FUNC_WRITE, 8'd3, 16'd7, 8'h0F, 1'b0);
    send_beat(FUNC_WRITE, 8'd3, 16'd7, 8'hFF, 1'b1);
    send_beat(FUNC_ERASE_ALL, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    send_beat(FUNC_READ,  8'd3, 16'd7, 8'h00, 1'b0);
    send_beat(FUNC_READ,  8'(SECTOR_COUNT - 1), 16'(SECTOR_BYTES - 1), 8'h00, 1'b1);

    // Random: mostly address runs closed by a last beat, some left open,
    // some running off the store, plus noise and erases
    wipes_left = 1;
    goal       = sent_cnt + RANDOM_BEATS;
    while (sent_cnt < goal) begin
      idle_on = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if (pick < 80) begin
          sec = 8'($urandom_range(0, SECTOR_COUNT - 1));
          off = $urandom_range(0, 1) ? 16'($urandom_range(0, 63))
                                     : 16'($urandom_range(0, SECTOR_BYTES - 1));
        end else begin
          sec = 8'(SECTOR_COUNT - 1);
          off = 16'(SECTOR_BYTES - $urandom_range(1, 8));
        end
        op       = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
        mixed    = ($urandom_range(0, 3) == 0);
        open_end = (pick >= 70 && pick < 80);
        for (int unsigned k = 0; k < n; k++) begin
          if (mixed) begin
            op = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
          end
          send_beat(op, sec, off + 16'(k), 8'($urandom_range(0, 255)),
                    (k == n - 1) && !open_end);
        end
      end else if (pick < 93) begin
        f = 2'($urandom_range(0, 3));
        if (f == FUNC_ERASE_ALL) begin
          if (wipes_left != 0) begin
            wipes_left--;
          end else begin
            f = FUNC_ERASE_SECTOR;
          end
        end
        send_beat(f, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 99) begin
        send_beat(FUNC_ERASE_SECTOR, 8'($urandom_range(0, SECTOR_COUNT - 1)),
                  16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (wipes_left != 0) begin
        wipes_left--;
        send_beat(FUNC_ERASE_ALL, 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
    end

    // Drop idling and close with one transfer of alternating reads and writes
    idle_on = 1'b0;
    sec     = 8'($urandom_range(0, SECTOR_COUNT - 1));
    for (int unsigned k = 0; k < TAIL_BEATS; k++) begin
      send_beat((k % 2 == 0) ? FUNC_READ : FUNC_WRITE, sec, 16'(k),
                8'($urandom_range(0, 255)), k == TAIL_BEATS - 1);
    end
    req_valid <= 1'b0;

    // Drain the outstanding responses, then watch for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
